>>> src/fibonacci_range_sum_mod_assert.svh
// Assertion macros for the Fibonacci range sum block.
// Included by the port checker; needs clk and arst_n in scope.
`ifndef FIBONACCI_RANGE_SUM_MOD_ASSERT_SVH
`define FIBONACCI_RANGE_SUM_MOD_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FRSM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled in reset
`define FRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> src/fsrm_pkg.sv
// Shared types, constants and modular helpers for the Fibonacci range sum block.
// No dependencies.
package fsrm_pkg;

	localparam int MOD_W          = 30;
	localparam int IDX_W          = 32;
	localparam int INDEX_BITS_DEF = 32;

	localparam logic [MOD_W-1:0] FIB_MOD  = 30'd1000000007;
	localparam logic [31:0]      FIB_MOD2 = 32'd2000000014;
	// Barrett constant floor(2^60 / p)
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(FIB_MOD));

	typedef struct packed {
		logic             vld;
		logic [MOD_W-1:0] x;
		logic [MOD_W-1:0] y;
	} mul_req_t;

	typedef struct packed {
		logic             vld;
		logic [MOD_W-1:0] r;
	} mul_rsp_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] value;
	} fib_rsp_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_SQA,
		E_SQB,
		E_CT,
		E_WAIT,
		E_DONE
	} fib_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_HI,
		T_LO_GO,
		T_LO,
		T_OUT
	} top_state_t;

	function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] x,
		input logic [MOD_W-1:0] y);
		logic [MOD_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, FIB_MOD}) begin
			s = s - {1'b0, FIB_MOD};
		end
		return s[MOD_W-1:0];
	endfunction

	function automatic logic [MOD_W-1:0] mod_sub(input logic [MOD_W-1:0] x,
		input logic [MOD_W-1:0] y);
		logic [MOD_W:0] s;
		if (x >= y) begin
			s = {1'b0, x} - {1'b0, y};
		end else begin
			s = {1'b0, x} + {1'b0, FIB_MOD} - {1'b0, y};
		end
		return s[MOD_W-1:0];
	endfunction

endpackage

>>> src/fsrm_modmul.sv
// Four-stage pipelined multiplier modulo 1000000007 (Barrett reduction).
// Depends on fsrm_pkg.
module fsrm_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  fsrm_pkg::mul_req_t req,
	output fsrm_pkg::mul_rsp_t rsp
);

	logic [59:0] prod_d;
	logic [59:0] prod_s1;
	logic [61:0] qm_d;
	logic [30:0] q_s2;
	logic [31:0] xlo_s2;
	logic [31:0] qp_d;
	logic [31:0] qp_s3;
	logic [31:0] xlo_s3;
	logic [31:0] rem_d;
	logic [fsrm_pkg::MOD_W-1:0] res_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign prod_d = req.x * req.y;
	// q = ((x >> 29) * mu) >> 31, off from floor(x/p) by at most 2
	assign qm_d   = prod_s1[59:29] * fsrm_pkg::BARRETT_MU;
	// only the low word of q*p matters, remainder < 3p < 2^32
	assign qp_d   = {1'b0, q_s2} * {2'b00, fsrm_pkg::FIB_MOD};
	assign rem_d  = xlo_s3 - qp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		q_s2    <= qm_d[61:31];
		xlo_s2  <= prod_s1[31:0];
		qp_s3   <= qp_d;
		xlo_s3  <= xlo_s2;
		if (rem_d >= fsrm_pkg::FIB_MOD2) begin
			res_s4 <= fsrm_pkg::MOD_W'(rem_d - fsrm_pkg::FIB_MOD2);
		end else if (rem_d >= {2'b00, fsrm_pkg::FIB_MOD}) begin
			res_s4 <= fsrm_pkg::MOD_W'(rem_d - {2'b00, fsrm_pkg::FIB_MOD});
		end else begin
			res_s4 <= rem_d[fsrm_pkg::MOD_W-1:0];
		end
	end

	assign rsp.vld = vld_s4;
	assign rsp.r   = res_s4;

endmodule

>>> src/fsrm_fib.sv
// Fast-doubling Fibonacci sequencer: F(k) mod p on the shared modular multiplier.
// Depends on fsrm_pkg and fsrm_modmul.
module fsrm_fib #(
	parameter int EXP_W = fsrm_pkg::INDEX_BITS_DEF + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [EXP_W-1:0]   k,
	output fsrm_pkg::fib_rsp_t rsp
);

	localparam int CNT_W = $clog2(EXP_W);
	// order of results out of the multiplier within one doubling step
	localparam logic [1:0] RES_A2 = 2'd0;
	localparam logic [1:0] RES_B2 = 2'd1;
	localparam logic [1:0] RES_CT = 2'd2;

	fsrm_pkg::fib_state_t state_q, state_d;
	fsrm_pkg::mul_req_t   mreq;
	fsrm_pkg::mul_rsp_t   mrsp;

	logic [EXP_W-1:0] k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       res_cnt_q;
	logic             started_q;
	// a = F(j), b = F(j+1) for the prefix j of k seen so far
	logic [fsrm_pkg::MOD_W-1:0] a_q, b_q, t_q, sqa_q, d_q;
	logic cur_bit, skip, last, step_done;

	assign cur_bit   = k_q[EXP_W-1];
	assign skip      = (state_q == fsrm_pkg::E_SQA) && !started_q && !cur_bit;
	assign last      = (cnt_q == '0);
	assign step_done = mrsp.vld && (res_cnt_q == RES_CT);

	fsrm_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fsrm_pkg::E_IDLE: begin
				if (start) state_d = fsrm_pkg::E_SQA;
			end
			fsrm_pkg::E_SQA: begin
				if (skip) begin
					if (last) state_d = fsrm_pkg::E_DONE;
				end else begin
					state_d = fsrm_pkg::E_SQB;
				end
			end
			fsrm_pkg::E_SQB:  state_d = fsrm_pkg::E_CT;
			fsrm_pkg::E_CT:   state_d = fsrm_pkg::E_WAIT;
			fsrm_pkg::E_WAIT: begin
				if (step_done) state_d = last ? fsrm_pkg::E_DONE : fsrm_pkg::E_SQA;
			end
			fsrm_pkg::E_DONE: state_d = fsrm_pkg::E_IDLE;
			default:          state_d = fsrm_pkg::E_IDLE;
		endcase
	end

	always_comb begin
		mreq.vld = 1'b0;
		mreq.x   = a_q;
		mreq.y   = a_q;
		case (state_q)
			fsrm_pkg::E_SQA: begin
				mreq.vld = !skip;
			end
			fsrm_pkg::E_SQB: begin
				mreq.vld = 1'b1;
				mreq.x   = b_q;
				mreq.y   = b_q;
			end
			fsrm_pkg::E_CT: begin
				mreq.vld = 1'b1;
				mreq.y   = t_q;
			end
			default: begin
				mreq.vld = 1'b0;
			end
		endcase
		rsp.done  = (state_q == fsrm_pkg::E_DONE);
		rsp.value = a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fsrm_pkg::E_IDLE;
			cnt_q     <= '0;
			res_cnt_q <= RES_A2;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fsrm_pkg::E_IDLE && start) begin
				cnt_q     <= CNT_W'(EXP_W - 1);
				res_cnt_q <= RES_A2;
				started_q <= 1'b0;
			end else begin
				if (state_q == fsrm_pkg::E_SQA && !skip) started_q <= 1'b1;
				if (skip || step_done) cnt_q <= cnt_q - 1'b1;
				if (mrsp.vld) begin
					case (res_cnt_q)
						RES_A2:  res_cnt_q <= RES_B2;
						RES_B2:  res_cnt_q <= RES_CT;
						default: res_cnt_q <= RES_A2;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fsrm_pkg::E_IDLE && start) begin
			k_q <= k;
			a_q <= '0;
			b_q <= fsrm_pkg::MOD_W'(1);
		end else begin
			if (state_q == fsrm_pkg::E_SQA) begin
				// t = 2*F(j+1) - F(j), so F(2j) = F(j) * t
				t_q <= fsrm_pkg::mod_sub(fsrm_pkg::mod_add(b_q, b_q), a_q);
			end
			if (skip) k_q <= k_q << 1;
			if (mrsp.vld) begin
				case (res_cnt_q)
					RES_A2: sqa_q <= mrsp.r;
					RES_B2: d_q   <= fsrm_pkg::mod_add(sqa_q, mrsp.r);
					default: begin
						// mrsp.r = F(2j), d_q = F(2j+1)
						k_q <= k_q << 1;
						if (cur_bit) begin
							a_q <= d_q;
							b_q <= fsrm_pkg::mod_add(mrsp.r, d_q);
						end else begin
							a_q <= mrsp.r;
							b_q <= d_q;
						end
					end
				endcase
			end
		end
	end

endmodule

>>> src/fibonacci_range_sum_mod.sv
// Fibonacci range sum modulo 1000000007. Each item carries indices n (first_index)
// and m (last_index), each cut to its low INDEX_BITS bits; the single result item is
// (F(m+2) - F(n+1)) mod 1000000007, i.e. F(n) + ... + F(m) when n <= m, and the
// wrapped modular difference otherwise. One item is in work at a time: in_stall is
// high from the cycle after acceptance until the result is loaded into the output
// register, which holds it until taken, so the next item can be accepted while a
// result still waits. Each Fibonacci value is built by fast doubling over the bits of
// its index, MSB first. Leading zero bits are skipped without a multiplier product;
// every bit from the first one on makes a round trip through the four-stage modular
// multiplier (three products per bit). No reset-time sweep; nothing is stored
// between items.
// Depends on fsrm_pkg, fsrm_fib, fsrm_modmul.
module fibonacci_range_sum_mod #(
	parameter int INDEX_BITS = fsrm_pkg::INDEX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fsrm_pkg::IDX_W-1:0] first_index,
	input  logic [fsrm_pkg::IDX_W-1:0] last_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [fsrm_pkg::MOD_W-1:0] sum_mod
);

	// index bits that survive both the port width and INDEX_BITS
	localparam int KEEP_BITS = (INDEX_BITS < fsrm_pkg::IDX_W) ? INDEX_BITS : fsrm_pkg::IDX_W;
	// one extra bit so that index + 2 never wraps
	localparam int EXP_W = KEEP_BITS + 1;

	fsrm_pkg::top_state_t state_q, state_d;
	fsrm_pkg::fib_rsp_t   frsp;

	logic [KEEP_BITS-1:0]        n_q;
	logic [fsrm_pkg::MOD_W-1:0]  hi_q;    // F(m+2)
	logic [fsrm_pkg::MOD_W-1:0]  lo_q;    // F(n+1)
	logic [fsrm_pkg::MOD_W-1:0]  sum_mod_q;
	logic                        out_valid_q;
	logic                        accept;
	logic                        load_out;
	logic                        fib_start;
	logic [EXP_W-1:0]            fib_k;

	assign accept   = in_valid && !in_stall;
	// result moves to the output register once the old one is gone or leaving
	assign load_out = (state_q == fsrm_pkg::T_OUT) && (!out_valid_q || !out_stall);

	// first run: F(m+2) straight from the port; second run: F(n+1)
	assign fib_start = accept || (state_q == fsrm_pkg::T_LO_GO);
	assign fib_k = (state_q == fsrm_pkg::T_IDLE)
		? (EXP_W'(last_index[KEEP_BITS-1:0]) + EXP_W'(2))
		: (EXP_W'(n_q) + EXP_W'(1));

	fsrm_fib #(
		.EXP_W (EXP_W)
	) u_fib (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fib_start),
		.k      (fib_k),
		.rsp    (frsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fsrm_pkg::T_IDLE:  if (in_valid) state_d = fsrm_pkg::T_HI;
			fsrm_pkg::T_HI:    if (frsp.done) state_d = fsrm_pkg::T_LO_GO;
			fsrm_pkg::T_LO_GO: state_d = fsrm_pkg::T_LO;
			fsrm_pkg::T_LO:    if (frsp.done) state_d = fsrm_pkg::T_OUT;
			fsrm_pkg::T_OUT:   if (load_out) state_d = fsrm_pkg::T_IDLE;
			default:           state_d = fsrm_pkg::T_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != fsrm_pkg::T_IDLE);
		out_valid = out_valid_q;
		sum_mod   = sum_mod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsrm_pkg::T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) n_q <= first_index[KEEP_BITS-1:0];
		if (state_q == fsrm_pkg::T_HI && frsp.done) hi_q <= frsp.value;
		if (state_q == fsrm_pkg::T_LO && frsp.done) lo_q <= frsp.value;
		// negative difference wraps by one modulus
		if (load_out) sum_mod_q <= fsrm_pkg::mod_sub(hi_q, lo_q);
	end

endmodule

>>> src/fsrm_checker.sv
// Port-level checker for the Fibonacci range sum block, bound to the top level.
// Depends on fsrm_pkg and fibonacci_range_sum_mod_assert.svh.
`include "fibonacci_range_sum_mod_assert.svh"

module fsrm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [fsrm_pkg::MOD_W-1:0] sum_mod
);

	`FRSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sum_mod), "stalled result changed")
	`FRSM_ASSERT_SAME(a_out_range, out_valid, sum_mod < fsrm_pkg::FIB_MOD, "result not reduced")
	`FRSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after item")
	`FRSM_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result too early")

endmodule

bind fibonacci_range_sum_mod fsrm_checker u_fsrm_checker (.*);

>>> test/tb_top.sv
// Testbench for fibonacci_range_sum_mod: sends index pairs and checks each sum_mod item
// against a matrix-power Fibonacci predictor kept in this file.
// Depends only on the block's RTL (fibonacci_range_sum_mod and the files it depends on).
module tb_top;

	// Run bounds. The limit covers all items at the block's worst-case item time
	// with the worst idling, taken several times over.
	localparam int          LIMIT_CYCLES = 3_000_000;
	localparam int          TAIL_CYCLES  = 600;
	localparam int          PHASE_ITEMS  = 258;
	localparam logic [63:0] PRIME        = 64'd1000000007;

	// 2x2 matrix {{a,b},{c,d}}, entries kept below the prime
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} fib_matrix_t;

	// one expected result item, with the indices that caused it for reporting
	typedef struct {
		logic [31:0] n;
		logic [31:0] m;
		logic [29:0] sum;
	} pending_sum_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [31:0] first_index = '0;
	logic [31:0] last_index  = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [29:0] sum_mod;

	pending_sum_t expected_sums[$];
	pending_sum_t oldest;
	int           errors        = 0;
	int           cycle_count   = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	fibonacci_range_sum_mod dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_index(first_index),
		.last_index (last_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum_mod    (sum_mod)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// product of two matrices, every entry reduced mod the prime
	function automatic fib_matrix_t matrix_product(input fib_matrix_t p, input fib_matrix_t q);
		fib_matrix_t r;
		r.a = ((p.a * q.a) % PRIME + (p.b * q.c) % PRIME) % PRIME;
		r.b = ((p.a * q.b) % PRIME + (p.b * q.d) % PRIME) % PRIME;
		r.c = ((p.c * q.a) % PRIME + (p.d * q.c) % PRIME) % PRIME;
		r.d = ((p.c * q.b) % PRIME + (p.d * q.d) % PRIME) % PRIME;
		return r;
	endfunction

	// F(k) mod prime: off-diagonal entry of {{1,1},{1,0}}^k, square-and-multiply.
	// k is 33 bits wide since m+2 of a full 32-bit index must not wrap.
	function automatic logic [63:0] fib_residue(input logic [32:0] k);
		fib_matrix_t acc;
		fib_matrix_t base;
		logic [32:0] e;
		acc  = '{64'd1, 64'd0, 64'd0, 64'd1};
		base = '{64'd1, 64'd1, 64'd1, 64'd0};
		e    = k;
		while (e != 0) begin
			if (e[0]) begin
				acc = matrix_product(acc, base);
			end
			base = matrix_product(base, base);
			e    = e >> 1;
		end
		return acc.b;
	endfunction

	// (F(m+2) - F(n+1)) mod prime; a negative difference gets the prime added once,
	// which also covers reversed ranges (n > m)
	function automatic logic [29:0] fib_range_sum(input logic [31:0] n, input logic [31:0] m);
		logic [63:0] upper;
		logic [63:0] lower;
		upper = fib_residue({1'b0, m} + 33'd2);
		lower = fib_residue({1'b0, n} + 33'd1);
		if (upper >= lower) begin
			return 30'(upper - lower);
		end
		return 30'(upper + PRIME - lower);
	endfunction

	// ---------------------------------------------------------------- driving

	// Called at a falling edge, returns at a falling edge. Valid stays high across
	// back-to-back items; it drops only during a random gap or while results drain.
	task automatic send_range(input logic [31:0] n, input logic [31:0] m);
		pending_sum_t rec;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		first_index <= n;
		last_index  <= m;
		// in_stall read right after the edge is the value the block saw there
		do begin
			@(posedge clk);
		end while (in_stall);
		rec.n   = n;
		rec.m   = m;
		rec.sum = fib_range_sum(n, m);
		expected_sums.push_back(rec);
		@(negedge clk);
	endtask

	// stop sending and hold off until every pending item has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// receiver: random stall, changed on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				$display("%0t: sum_mod %0d arrived with no item pending", $time, sum_mod);
				errors++;
			end else begin
				oldest = expected_sums.pop_front();
				if (sum_mod !== oldest.sum) begin
					$display("%0t: sum_mod mismatch for n=%0d m=%0d: expected %0d, got %0d",
						$time, oldest.n, oldest.m, oldest.sum, sum_mod);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Edge cases: zero and all-ones indices, single-term and empty ranges (n = m+1),
	// reversed ranges, alternating bit patterns so every index bit toggles.
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_range(32'd0, 32'd0);
		send_range(32'd0, 32'd1);
		send_range(32'd1, 32'd1);
		send_range(32'd0, 32'd2);
		send_range(32'd10, 32'd10);
		send_range(32'd2, 32'd100);
		send_range(32'd1, 32'd0);                      // empty range
		send_range(32'd1000, 32'd999);                 // empty range
		send_range(32'd5, 32'd2);                      // reversed
		send_range(32'd0, 32'hFFFF_FFFF);
		send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_range(32'hFFFF_FFFF, 32'd0);              // reversed, widest gap
		send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_range(32'hFFFF_FFFF, 32'hFFFF_FFFE);      // empty range at the top
		send_range(32'h8000_0000, 32'h8000_0000);
		send_range(32'hAAAA_AAAA, 32'h5555_5555);
		send_range(32'h5555_5555, 32'hAAAA_AAAA);
		wait_results_drained();
	endtask

	// mostly short indices to keep items fast; one in four is left unshifted
	function automatic logic [31:0] rand_index();
		logic [31:0] raw;
		raw = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			return raw;
		end
		return raw >> $urandom_range(0, 31);
	endfunction

	// Random pairs: mostly ordered ranges, plus single-term, empty and reversed ones.
	// Ends with the sender paused until all results are in.
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] t;
		int          pick;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			a    = rand_index();
			b    = rand_index();
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
			end else if (pick == 7) begin
				b = a;
			end else if (pick == 8) begin
				b = a - 32'd1;   // empty range, but for a = 0 wraps to all-ones, the full range
			end
			send_range(a, b);
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(0, 0, PHASE_ITEMS);
		test_random_phase(63, 0, PHASE_ITEMS);
		test_random_phase(0, 63, PHASE_ITEMS);
		test_random_phase(27, 27, PHASE_ITEMS);

		// any stray item from the block would show up here
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
